@@ hw/rtl/sipf_pkg.sv @@
package sipf_pkg;

  // Largest parameter count a packet may carry
  localparam int MAX_PARAMS = 252;

  // Fixed header bytes and CRC polynomial
  localparam logic [7:0]  HDR_SYNC  = 8'hFF;
  localparam logic [7:0]  HDR_THIRD = 8'hFD;
  localparam logic [7:0]  HDR_RSVD  = 8'h00;
  localparam logic [15:0] CRC_POLY  = 16'h8005;

  // Byte positions of the sequencer, in wire order
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_SYNC0  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_SYNC1  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_THIRD  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_RSVD   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_ID     = 4'd4;
  localparam logic [STEP_W-1:0] STEP_LEN_LO = 4'd5;
  localparam logic [STEP_W-1:0] STEP_LEN_HI = 4'd6;
  localparam logic [STEP_W-1:0] STEP_INST   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_PARAM  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_CRC_LO = 4'd9;
  localparam logic [STEP_W-1:0] STEP_CRC_HI = 4'd10;

  // Control from the sequencer to the CRC accumulator
  typedef struct packed {
    logic feed;     // fold the byte in
    logic restart;  // start from zero with this byte
  } crc_ctl_t;

  // One byte into CRC-16, MSB first, no reflection
  function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/sipf_item_if.sv @@
interface sipf_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] servo_id;
  logic [7:0] instruction_code;
  logic [7:0] param_count;
  logic [7:0] param_byte;

  modport source (output valid, servo_id, instruction_code, param_count, param_byte,
                  input ready);
  modport sink (input valid, servo_id, instruction_code, param_count, param_byte,
                output ready);
endinterface

@@ hw/rtl/sipf_tx_if.sv @@
interface sipf_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       end_of_packet;
  logic       end_of_run;

  modport source (output valid, tx_byte, end_of_packet, end_of_run, input ready);
  modport sink (input valid, tx_byte, end_of_packet, end_of_run, output ready);
endinterface

@@ hw/rtl/servo_instruction_packet_framer_unit.sv @@
// Instruction packet framer: turns requests into the byte stream of a servo-bus
// packet (header FF FF FD 00, id, length, instruction, parameters, CRC-16 with
// polynomial 0x8005 and initial value 0, low byte first). The first request of a
// packet carries id, instruction and count (clamped to MAX_PARAMS) and yields 8
// header bytes, its parameter byte when the count is not zero, and the CRC pair
// when the packet ends there. Each later request yields one parameter byte, plus
// the CRC pair on the last one. One byte leaves per cycle through the output
// register while tx is ready; the sequencer takes the next request in the cycle
// its current request's last byte moves into that register, so a stream of
// parameter requests runs at one per cycle unless tx stalls.
module servo_instruction_packet_framer_unit #(
  parameter int MAX_PARAMS = sipf_pkg::MAX_PARAMS
) (
  input  logic        clk,
  input  logic        rst,
  sipf_item_if.sink   item,
  sipf_tx_if.source   tx
);

  localparam logic [7:0] MaxCnt = 8'(MAX_PARAMS);

  // Packet state
  logic        in_packet;
  logic [7:0]  params_left;

  // Held request
  logic                        busy;
  logic [sipf_pkg::STEP_W-1:0] step;
  logic [7:0]                  id_q;
  logic [7:0]                  inst_q;
  logic [7:0]                  len_q;
  logic [7:0]                  pb_q;
  logic                        has_param_q;
  logic                        ends_q;

  // Output register
  logic       ov;
  logic [7:0] tx_q;
  logic       eop_q;
  logic       eor_q;

  logic [15:0] crc;
  sipf_pkg::crc_ctl_t crc_ctl;

  logic                        advance;
  logic                        last;
  logic                        accept;
  logic [7:0]                  cnt_c;
  logic                        has_param_new;
  logic [7:0]                  left_new;
  logic [sipf_pkg::STEP_W-1:0] start_new;
  logic [sipf_pkg::STEP_W-1:0] step_next;
  logic [7:0]                  byte_sel;

  // Handshake
  assign advance    = busy && (!ov || tx.ready);
  assign item.ready = !busy || (advance && last);
  assign accept     = item.valid && item.ready;

  // Decode the request against the packet state
  always_comb begin
    cnt_c = (item.param_count > MaxCnt) ? MaxCnt : item.param_count;
    if (!in_packet) begin
      has_param_new = (cnt_c != 8'd0);
      left_new      = has_param_new ? cnt_c - 8'd1 : 8'd0;
      start_new     = sipf_pkg::STEP_SYNC0;
    end else begin
      has_param_new = 1'b1;
      left_new      = (params_left != 8'd0) ? params_left - 8'd1 : 8'd0;
      start_new     = sipf_pkg::STEP_PARAM;
    end
  end

  // Pick the byte of the current step
  always_comb begin
    case (step)
      sipf_pkg::STEP_SYNC0:  byte_sel = sipf_pkg::HDR_SYNC;
      sipf_pkg::STEP_SYNC1:  byte_sel = sipf_pkg::HDR_SYNC;
      sipf_pkg::STEP_THIRD:  byte_sel = sipf_pkg::HDR_THIRD;
      sipf_pkg::STEP_RSVD:   byte_sel = sipf_pkg::HDR_RSVD;
      sipf_pkg::STEP_ID:     byte_sel = id_q;
      sipf_pkg::STEP_LEN_LO: byte_sel = len_q;
      sipf_pkg::STEP_LEN_HI: byte_sel = 8'h00;
      sipf_pkg::STEP_INST:   byte_sel = inst_q;
      sipf_pkg::STEP_PARAM:  byte_sel = pb_q;
      sipf_pkg::STEP_CRC_LO: byte_sel = crc[7:0];
      sipf_pkg::STEP_CRC_HI: byte_sel = crc[15:8];
      default:               byte_sel = 8'h00;
    endcase
  end

  // Next step and end of the request
  always_comb begin
    last      = (step == sipf_pkg::STEP_CRC_HI) || (step == sipf_pkg::STEP_PARAM && !ends_q);
    step_next = step + 4'd1;
    if (step == sipf_pkg::STEP_INST && !has_param_q) begin
      step_next = sipf_pkg::STEP_CRC_LO;
    end
  end

  // Feed header and parameter bytes into the CRC
  always_comb begin
    crc_ctl.feed    = advance && (step <= sipf_pkg::STEP_PARAM);
    crc_ctl.restart = (step == sipf_pkg::STEP_SYNC0);
  end

  sipf_crc u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctl  (crc_ctl),
    .data (byte_sel),
    .crc  (crc)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet   <= 1'b0;
      params_left <= 8'd0;
      busy        <= 1'b0;
      step        <= sipf_pkg::STEP_SYNC0;
      ov          <= 1'b0;
    end else begin
      if (accept) begin
        in_packet   <= (left_new != 8'd0);
        params_left <= left_new;
        busy        <= 1'b1;
        step        <= start_new;
      end else if (advance) begin
        if (last) begin
          busy <= 1'b0;
        end else begin
          step <= step_next;
        end
      end
      if (advance) begin
        ov <= 1'b1;
      end else if (tx.ready) begin
        ov <= 1'b0;
      end
    end
  end

  // Hold the request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      id_q        <= item.servo_id;
      inst_q      <= item.instruction_code;
      len_q       <= cnt_c + 8'd3;
      pb_q        <= item.param_byte;
      has_param_q <= has_param_new;
      ends_q      <= (left_new == 8'd0);
    end
  end

  // Load the output byte
  always_ff @(posedge clk) begin
    if (advance) begin
      tx_q  <= byte_sel;
      eop_q <= (step == sipf_pkg::STEP_CRC_HI);
      eor_q <= last;
    end
  end

  assign tx.valid         = ov;
  assign tx.tx_byte       = tx_q;
  assign tx.end_of_packet = eop_q;
  assign tx.end_of_run    = eor_q;

endmodule

@@ hw/rtl/sipf_crc.sv @@
module sipf_crc (
  input  logic               clk,
  input  logic               rst,
  input  sipf_pkg::crc_ctl_t ctl,
  input  logic [7:0]         data,
  output logic [15:0]        crc
);

  logic [15:0] crc_next;

  // Fold in the byte whenever feed is set; restart on the first header byte
  always_comb begin
    crc_next = crc;
    if (ctl.feed) begin
      crc_next = sipf_pkg::crc_feed(ctl.restart ? 16'h0000 : crc, data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= 16'h0000;
    end else begin
      crc <= crc_next;
    end
  end

endmodule

@@ hw/rtl/sipf_chk.sv @@
module sipf_chk (
  input logic       clk,
  input logic       rst,
  input logic       tx_valid,
  input logic       tx_ready,
  input logic [7:0] tx_byte,
  input logic       tx_eop,
  input logic       tx_eor
);

  // Stalled output byte holds
  a_tx_hold: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid && $stable(tx_byte) && $stable(tx_eop)
      && $stable(tx_eor))
    else $error("output byte changed under stall");

  // CRC high byte always closes the request
  a_eop_eor: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_eop |-> tx_eor)
    else $error("end of packet without end of run");

  // Nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !tx_valid)
    else $error("output valid straight after reset");

  // A packet that follows back to back opens with a sync byte
  a_next_sync: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_ready && tx_eop ##1 tx_valid |-> tx_byte == sipf_pkg::HDR_SYNC)
    else $error("packet does not open with sync byte");

endmodule

bind servo_instruction_packet_framer_unit sipf_chk u_sipf_chk (
  .clk      (clk),
  .rst      (rst),
  .tx_valid (tx.valid),
  .tx_ready (tx.ready),
  .tx_byte  (tx.tx_byte),
  .tx_eop   (tx.end_of_packet),
  .tx_eor   (tx.end_of_run)
);
